[src/bfs_pkg.sv]
// Shared constants, opcodes and opcode helpers of the bit field store.
package bfs_pkg;

  // Fixed payload widths
  localparam int OP_BITS   = 4;
  localparam int IDX_BITS  = 10;
  localparam int LEN_BITS  = 6;
  localparam int LENX_BITS = LEN_BITS + 1;
  localparam int VAL_BITS  = 32;
  // Bit position width: any start index plus a two-word window
  localparam int POS_BITS  = IDX_BITS + 1;

  // Parameter defaults
  localparam int STORE_BITS_DEF     = 1024;
  localparam int MAX_FIELD_BITS_DEF = 32;

  typedef logic [OP_BITS-1:0] op_t;

  // Opcodes
  localparam op_t OP_SET       = 4'd0;
  localparam op_t OP_CLR       = 4'd1;
  localparam op_t OP_INV       = 4'd2;
  localparam op_t OP_GET       = 4'd3;
  localparam op_t OP_RD_UINT   = 4'd4;
  localparam op_t OP_RD_SM     = 4'd5;
  localparam op_t OP_RD_GRAY   = 4'd6;
  localparam op_t OP_RD_GRAYSM = 4'd7;
  localparam op_t OP_WR_UINT   = 4'd8;
  localparam op_t OP_WR_SM     = 4'd9;
  localparam op_t OP_WR_GRAY   = 4'd10;
  localparam op_t OP_RAND      = 4'd11;

  // Operation returns one item on the result channel
  function automatic logic has_result(input op_t op);
    logic r;
    r = (op == OP_GET) || (op == OP_RD_UINT) || (op == OP_RD_SM) ||
        (op == OP_RD_GRAY) || (op == OP_RD_GRAYSM);
    return r;
  endfunction

  // Operation modifies the store
  function automatic logic is_write(input op_t op);
    logic r;
    r = (op == OP_SET) || (op == OP_CLR) || (op == OP_INV) || (op == OP_WR_UINT) ||
        (op == OP_WR_SM) || (op == OP_WR_GRAY) || (op == OP_RAND);
    return r;
  endfunction

endpackage

[src/bfs_bank.sv]
// One bank of store words: synchronous read, one write port, per-word valid bits.
module bfs_bank #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic          rd_in_range,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [W-1:0]     q_r;
  logic             hit_r;

  // Storage array and registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: a word never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= rd_in_range && vld_r[rd_addr];
      end
    end
  end

  assign rd_data = hit_r ? q_r : '0;

endmodule

[src/bfs_field.sv]
// Field extract, decode, encode and merge over a two-word bit window.
module bfs_field #(
  parameter int W  = 32,
  parameter int LW = 5,
  parameter int MF = 32
) (
  input  bfs_pkg::op_t                 op,
  input  logic [LW-1:0]                off,
  input  logic [bfs_pkg::LEN_BITS-1:0] len,
  input  logic [bfs_pkg::VAL_BITS-1:0] wv,
  input  logic                         rb,
  input  logic [2*W-1:0]               win,
  output logic [bfs_pkg::VAL_BITS-1:0] rd_value,
  output logic [2*W-1:0]               new_win
);

  localparam int SHW = $clog2(2 * W) + 1;

  // Low k bits set, all set for k >= MF
  function automatic logic [MF-1:0] lmask(input logic [bfs_pkg::LENX_BITS-1:0] k);
    logic [MF-1:0] m;
    m = ~({MF{1'b1}} << k);
    return m;
  endfunction

  logic [2*W-1:0]               shifted;
  logic [MF-1:0]                fld;
  logic [MF-1:0]                raw;
  logic [MF-1:0]                dec;
  logic [MF-1:0]                v;
  logic                         bit_old;
  logic [bfs_pkg::LEN_BITS-1:0] lenm1;
  logic [MF-1:0]                sgn_sh;
  logic                         sgn;
  logic [MF-1:0]                mag;
  logic [bfs_pkg::VAL_BITS-1:0] sm_val;

  logic [MF-1:0]                 nv;
  logic [bfs_pkg::LENX_BITS-1:0] wl;
  logic [bfs_pkg::VAL_BITS-1:0]  neg_wv;
  logic [MF-1:0]                 g;
  logic [SHW-1:0]                sh_amt;
  logic [2*W-1:0]                nv2;
  logic [2*W-1:0]                m2;

  // Extract: field starts at the window MSB after shifting by the offset
  always_comb begin
    shifted = win << off;
    fld     = shifted[2*W-1 -: MF];
    raw     = fld >> (SHW'(MF) - SHW'(len));
    bit_old = shifted[2*W-1];
  end

  // Gray decode: each bit is the XOR of all bits above and including it
  always_comb begin
    for (int i = 0; i < MF; i++) begin
      dec[i] = ^(raw >> i);
    end
  end

  // Sign-magnitude decode
  always_comb begin
    v      = ((op == bfs_pkg::OP_RD_GRAY) || (op == bfs_pkg::OP_RD_GRAYSM)) ? dec : raw;
    lenm1  = len - 1'b1;
    sgn_sh = v >> lenm1;
    sgn    = sgn_sh[0];
    mag    = v & lmask(bfs_pkg::LENX_BITS'(lenm1));
    if (len == '0) begin
      sm_val = '0;
    end else if (sgn) begin
      sm_val = bfs_pkg::VAL_BITS'(0) - bfs_pkg::VAL_BITS'(mag);
    end else begin
      sm_val = bfs_pkg::VAL_BITS'(mag);
    end
  end

  // Result selection
  always_comb begin
    unique case (op)
      bfs_pkg::OP_GET:                           rd_value = bfs_pkg::VAL_BITS'(bit_old);
      bfs_pkg::OP_RD_SM, bfs_pkg::OP_RD_GRAYSM:  rd_value = sm_val;
      default:                                   rd_value = bfs_pkg::VAL_BITS'(v);
    endcase
  end

  // Encode the new field value, right aligned, with its length
  always_comb begin
    neg_wv = bfs_pkg::VAL_BITS'(0) - wv;
    g      = MF'(wv) & lmask(bfs_pkg::LENX_BITS'(len));
    nv     = '0;
    wl     = '0;
    unique case (op)
      bfs_pkg::OP_SET: begin
        nv = MF'(1'b1);
        wl = bfs_pkg::LENX_BITS'(1);
      end
      bfs_pkg::OP_CLR: begin
        nv = '0;
        wl = bfs_pkg::LENX_BITS'(1);
      end
      bfs_pkg::OP_INV: begin
        nv = MF'(~bit_old);
        wl = bfs_pkg::LENX_BITS'(1);
      end
      bfs_pkg::OP_RAND: begin
        nv = MF'(rb);
        wl = bfs_pkg::LENX_BITS'(1);
      end
      bfs_pkg::OP_WR_UINT: begin
        nv = MF'(wv);
        wl = bfs_pkg::LENX_BITS'(len);
      end
      bfs_pkg::OP_WR_SM: begin
        // sign goes to the field's first bit, magnitude below it
        nv = wv[bfs_pkg::VAL_BITS-1] ? MF'(neg_wv) : MF'(wv);
        nv = (nv & ~(MF'(1'b1) << lenm1)) |
             (MF'(wv[bfs_pkg::VAL_BITS-1]) << lenm1);
        wl = bfs_pkg::LENX_BITS'(len);
      end
      bfs_pkg::OP_WR_GRAY: begin
        nv = g ^ (g >> 1);
        wl = bfs_pkg::LENX_BITS'(len);
      end
      default: begin
        nv = '0;
        wl = '0;
      end
    endcase
  end

  // Merge the field back into the window
  always_comb begin
    sh_amt  = SHW'(2 * W) - SHW'(off) - SHW'(wl);
    nv2     = (2 * W)'(nv) << sh_amt;
    m2      = (2 * W)'(lmask(wl)) << sh_amt;
    new_win = (win & ~m2) | (nv2 & m2);
  end

endmodule

[src/bitstring_field_store_top.sv]
// Top level of the bit field store: handshake, two word banks, output register.
//
//   channel  direction  handshake                payload
//   in_      input      in_valid / in_ready      opcode, bit_index, field_length,
//                                                write_value, random_bit
//   out_     output     out_valid / out_ready    read_value
//
// For each item, the accept cycle issues reads of the two words that
// hold the field (even and odd banks, read together), the next cycle decodes,
// merges and, for a modifying item, writes both words back. A result-producing
// item waits in ST_MOD while the output register holds an untaken item. Synchronous
// reset clears control and all valid bits at once; no clearing pass is needed.
module bitstring_field_store_top #(
  parameter int STORE_BITS     = bfs_pkg::STORE_BITS_DEF,
  parameter int MAX_FIELD_BITS = bfs_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfs_pkg::OP_BITS-1:0]  in_opcode,
  input  logic [bfs_pkg::IDX_BITS-1:0] in_bit_index,
  input  logic [bfs_pkg::LEN_BITS-1:0] in_field_length,
  input  logic [bfs_pkg::VAL_BITS-1:0] in_write_value,
  input  logic                         in_random_bit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bfs_pkg::VAL_BITS-1:0] out_read_value
);

  // Word geometry: word width is the field limit rounded up to a power of two
  localparam int LW    = $clog2(MAX_FIELD_BITS);
  localparam int W     = 1 << LW;
  localparam int REACH = (1 << bfs_pkg::IDX_BITS) + W;
  localparam int EFF   = (STORE_BITS < REACH) ? STORE_BITS : REACH;
  localparam int NW    = (EFF + W - 1) / W;
  localparam int BD    = (NW + 1) / 2;
  localparam int BAW   = (BD > 1) ? $clog2(BD) : 1;
  localparam int SHW   = $clog2(2 * W) + 1;
  localparam int PW    = bfs_pkg::POS_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOD  = 1'b1;

  logic state_r, state_nxt;

  bfs_pkg::op_t                 op_r;
  logic [LW-1:0]                off_r;
  logic [bfs_pkg::LEN_BITS-1:0] len_r;
  logic [bfs_pkg::VAL_BITS-1:0] wv_r;
  logic                         rb_r;
  logic                         b0_r;
  logic [BAW-1:0]               ev_addr_r, od_addr_r;
  logic                         ev_ok_r, od_ok_r;
  logic [2*W-1:0]               rng_mask_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [bfs_pkg::VAL_BITS-1:0] out_val_r;

  logic                         accept;
  logic                         finish;
  logic [PW-1:0]                b_pos, b1_pos, ev_addr, od_addr, base_pos;
  logic [SHW-1:0]               rem;
  logic [2*W-1:0]               rng_mask;
  logic [bfs_pkg::LEN_BITS-1:0] len_sat;

  logic [W-1:0]                 ev_q, od_q;
  logic [2*W-1:0]               win, new_win;
  logic [bfs_pkg::VAL_BITS-1:0] rd_value;
  logic                         wr_en;
  logic [W-1:0]                 ev_wdata, od_wdata;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Word addresses: word b and b+1 always sit in opposite banks
  always_comb begin
    b_pos    = PW'(in_bit_index) >> LW;
    b1_pos   = b_pos + 1'b1;
    ev_addr  = b1_pos >> 1;
    od_addr  = b_pos >> 1;
    base_pos = b_pos << LW;
    len_sat  = ({1'b0, in_field_length} > bfs_pkg::LENX_BITS'(MAX_FIELD_BITS)) ?
               bfs_pkg::LEN_BITS'(MAX_FIELD_BITS) : in_field_length;
  end

  // Window bits past the store end read as zero
  always_comb begin
    if (base_pos >= PW'(EFF)) begin
      rem = '0;
    end else if ((PW'(EFF) - base_pos) >= PW'(2 * W)) begin
      rem = SHW'(2 * W);
    end else begin
      rem = SHW'(PW'(EFF) - base_pos);
    end
    rng_mask = ~({(2 * W){1'b1}} >> rem);
  end

  // Item registers, loaded at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_opcode;
      off_r      <= in_bit_index[LW-1:0];
      len_r      <= len_sat;
      wv_r       <= in_write_value;
      rb_r       <= in_random_bit;
      b0_r       <= b_pos[0];
      ev_addr_r  <= ev_addr[BAW-1:0];
      od_addr_r  <= od_addr[BAW-1:0];
      ev_ok_r    <= (ev_addr < PW'(BD));
      od_ok_r    <= (od_addr < PW'(BD));
      rng_mask_r <= rng_mask;
    end
  end

  // Word banks
  bfs_bank #(.DEPTH(BD), .AW(BAW), .W(W)) u_bank_ev (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (accept),
    .rd_in_range (ev_addr < PW'(BD)),
    .rd_addr     (ev_addr[BAW-1:0]),
    .rd_data     (ev_q),
    .wr_en       (wr_en && ev_ok_r),
    .wr_addr     (ev_addr_r),
    .wr_data     (ev_wdata)
  );

  bfs_bank #(.DEPTH(BD), .AW(BAW), .W(W)) u_bank_od (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (accept),
    .rd_in_range (od_addr < PW'(BD)),
    .rd_addr     (od_addr[BAW-1:0]),
    .rd_data     (od_q),
    .wr_en       (wr_en && od_ok_r),
    .wr_addr     (od_addr_r),
    .wr_data     (od_wdata)
  );

  // Window: word b in the upper half, word b+1 in the lower half
  assign win = (b0_r ? {od_q, ev_q} : {ev_q, od_q}) & rng_mask_r;

  bfs_field #(.W(W), .LW(LW), .MF(MAX_FIELD_BITS)) u_field (
    .op       (op_r),
    .off      (off_r),
    .len      (len_r),
    .wv       (wv_r),
    .rb       (rb_r),
    .win      (win),
    .rd_value (rd_value),
    .new_win  (new_win)
  );

  // Completion: a read waits only while the output register is occupied and not taken
  assign finish   = (state_r == ST_MOD) &&
                    !(bfs_pkg::has_result(op_r) && out_valid_r && !out_ready);
  assign wr_en    = finish && bfs_pkg::is_write(op_r);
  assign ev_wdata = b0_r ? new_win[W-1:0] : new_win[2*W-1:W];
  assign od_wdata = b0_r ? new_win[2*W-1:W] : new_win[W-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        state_nxt = ST_MOD;
      end
      ST_MOD: if (finish) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    if (finish && bfs_pkg::has_result(op_r)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && bfs_pkg::has_result(op_r)) begin
      out_val_r <= rd_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;

endmodule
